### rtl/core/tgapd_pkg.sv
`timescale 1ns / 1ps
// Package for the TGA pixel stream decoder: register indexes, widths and packet constants.
// It has no dependencies. The decoder core imports it.

package tgapd_pkg;

    // Width of the pixel counters. The pixel total register keeps only this many bits.
    localparam int COUNT_WIDTH = 32;

    // Configuration port widths.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int BPP_W   = 3;
    localparam int SLOT_W  = 2;
    localparam int HELD_W  = 24;
    localparam int COUNT_W = 8;

    typedef logic [CFG_INDEX_W-1:0] t_reg_index;

    // Configuration register indexes.
    localparam t_reg_index REG_BYTES_PER_PIXEL  = 2'd0;
    localparam t_reg_index REG_PIXEL_TOTAL      = 2'd1;
    localparam t_reg_index REG_RUN_LENGTH_CODED = 2'd2;

    // Register reset values.
    localparam logic [BPP_W-1:0]       BPP_RESET   = 3'd3;
    localparam logic [COUNT_WIDTH-1:0] TOTAL_RESET = COUNT_WIDTH'(1);

    // Pixel size code that selects four-byte BGRA pixels.
    localparam logic [BPP_W-1:0] BPP_BGRA = 3'd4;

    // Index of the last byte within a pixel for each pixel size.
    localparam logic [SLOT_W-1:0] LAST_SLOT_BGR  = 2'd2;
    localparam logic [SLOT_W-1:0] LAST_SLOT_BGRA = 2'd3;

    // Packet byte layout: bit 7 marks a run packet, the low seven bits hold count minus one.
    localparam int                 PKT_RUN_BIT  = 7;
    localparam logic [BYTE_W-1:0]  PKT_LEN_MASK = 8'd127;

endpackage

### rtl/core/tga_pixel_stream_decoder.sv
`timescale 1ns / 1ps
// A pixel result is registered and appears in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; a byte that causes no result is taken even while a
// result waits in the output register, and a result byte is taken once that register frees.
// Reset (synchronous, active low) sets 3-byte pixels, a total of one pixel and run-length
// coding, and restarts the decoder. Any register write also restarts the decoder.
// Depends on tgapd_pkg.

module tga_pixel_stream_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  tgapd_pkg::t_reg_index          i_cfg_index,
    input  logic [tgapd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input byte channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_data_byte,
    // Pixel result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue,
    output logic [7:0]                     o_alpha,
    output logic [7:0]                     o_repeat_res,
    output logic                           o_end_of_image
);
    import tgapd_pkg::*;

    // Configuration registers.
    logic [BPP_W-1:0]       r_bytes_per_pixel;
    logic [COUNT_WIDTH-1:0] r_pixel_total;
    logic                   r_coded;

    // Decoder state.
    logic                   r_expect_packet;
    logic                   r_packet_is_run;
    logic [COUNT_W-1:0]     r_packet_left;
    logic [SLOT_W-1:0]      r_slot;
    logic [HELD_W-1:0]      r_held;
    logic [COUNT_WIDTH-1:0] r_remaining;
    logic                   r_done;

    // Output register.
    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_red, r_green, r_blue, r_alpha;
    logic [COUNT_W-1:0]     r_repeat;
    logic                   r_eoi;

    // Next values.
    logic                   n_expect_packet;
    logic                   n_packet_is_run;
    logic [COUNT_W-1:0]     n_packet_left;
    logic [SLOT_W-1:0]      n_slot;
    logic [HELD_W-1:0]      n_held;
    logic [COUNT_WIDTH-1:0] n_remaining;
    logic                   n_done;
    logic [BYTE_W-1:0]      n_red, n_alpha;
    logic [COUNT_W-1:0]     n_repeat;
    logic                   n_eoi;

    logic [SLOT_W-1:0]      last_slot;
    logic                   in_packet_byte;
    logic                   will_emit;
    logic                   in_fire;
    logic                   cfg_hit;
    logic [COUNT_W-1:0]     run_len;
    logic                   rem_small;
    logic [COUNT_W-1:0]     rem_low;

    // Decode of the current byte's role; it depends on state only, not on the byte.
    assign last_slot      = (r_bytes_per_pixel == BPP_BGRA) ? LAST_SLOT_BGRA : LAST_SLOT_BGR;
    assign in_packet_byte = r_coded && r_expect_packet;
    assign will_emit      = !r_done && !in_packet_byte && (r_slot == last_slot);

    // A byte that yields no result never waits on the output side.
    assign o_in_ready = !r_out_valid || i_out_ready || !will_emit;
    assign in_fire    = i_in_valid && o_in_ready;

    assign cfg_hit = i_cfg_we && ((i_cfg_index == REG_BYTES_PER_PIXEL) ||
                                  (i_cfg_index == REG_PIXEL_TOTAL) ||
                                  (i_cfg_index == REG_RUN_LENGTH_CODED));

    // Repeat count: run length (at least one), clipped to the pixels remaining.
    assign run_len   = (r_packet_left == '0) ? COUNT_W'(1) : r_packet_left;
    assign rem_small = (r_remaining[COUNT_WIDTH-1:COUNT_W] == '0);
    assign rem_low   = r_remaining[COUNT_W-1:0];

    // Next state for one accepted byte.
    always_comb begin
        n_expect_packet = r_expect_packet;
        n_packet_is_run = r_packet_is_run;
        n_packet_left   = r_packet_left;
        n_slot          = r_slot;
        n_held          = r_held;
        n_remaining     = r_remaining;
        n_done          = r_done;
        n_red           = i_data_byte;
        n_alpha         = '0;
        n_repeat        = COUNT_W'(1);
        n_eoi           = 1'b0;

        if (r_done) begin
            // Image complete: the byte is dropped.
        end else if (in_packet_byte) begin
            n_packet_is_run = i_data_byte[PKT_RUN_BIT];
            n_packet_left   = (i_data_byte & PKT_LEN_MASK) + COUNT_W'(1);
            n_expect_packet = 1'b0;
            n_slot          = '0;
        end else if (r_slot != last_slot) begin
            // Collect blue, green and, for four-byte pixels, red.
            n_held[r_slot*BYTE_W +: BYTE_W] = i_data_byte;
            n_slot = r_slot + SLOT_W'(1);
        end else begin
            n_slot = '0;
            if (last_slot == LAST_SLOT_BGRA) begin
                n_red   = r_held[2*BYTE_W +: BYTE_W];
                n_alpha = i_data_byte;
            end

            if (r_coded && r_packet_is_run) begin
                n_repeat      = (rem_small && (run_len > rem_low)) ? rem_low : run_len;
                n_packet_left = '0;
            end else if (r_packet_left != '0) begin
                n_packet_left = r_packet_left - COUNT_W'(1);
            end

            if (r_coded && (n_packet_left == '0)) begin
                n_expect_packet = 1'b1;
            end

            n_remaining = r_remaining - COUNT_WIDTH'(n_repeat);
            n_eoi       = rem_small && (n_repeat == rem_low);
            n_done      = n_eoi;
        end
    end

    // Configuration registers and decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_pixel <= BPP_RESET;
            r_pixel_total     <= TOTAL_RESET;
            r_coded           <= 1'b1;
            r_expect_packet   <= 1'b1;
            r_packet_is_run   <= 1'b0;
            r_packet_left     <= '0;
            r_slot            <= '0;
            r_held            <= '0;
            r_remaining       <= TOTAL_RESET;
            r_done            <= 1'b0;
        end else if (cfg_hit) begin
            // A register write restarts the stream.
            r_expect_packet <= 1'b1;
            r_packet_is_run <= 1'b0;
            r_packet_left   <= '0;
            r_slot          <= '0;
            r_held          <= '0;
            r_remaining     <= r_pixel_total;
            r_done          <= (r_pixel_total == '0);
            unique case (i_cfg_index)
                REG_BYTES_PER_PIXEL: begin
                    r_bytes_per_pixel <= i_cfg_data[BPP_W-1:0];
                end
                REG_PIXEL_TOTAL: begin
                    r_pixel_total <= i_cfg_data[COUNT_WIDTH-1:0];
                    r_remaining   <= i_cfg_data[COUNT_WIDTH-1:0];
                    r_done        <= (i_cfg_data[COUNT_WIDTH-1:0] == '0);
                end
                REG_RUN_LENGTH_CODED: begin
                    r_coded <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (in_fire) begin
            r_expect_packet <= n_expect_packet;
            r_packet_is_run <= n_packet_is_run;
            r_packet_left   <= n_packet_left;
            r_slot          <= n_slot;
            r_held          <= n_held;
            r_remaining     <= n_remaining;
            r_done          <= n_done;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && will_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded with each new pixel transaction.
    always_ff @(posedge i_clk) begin
        if (in_fire && will_emit) begin
            r_red    <= n_red;
            r_green  <= r_held[BYTE_W +: BYTE_W];
            r_blue   <= r_held[0 +: BYTE_W];
            r_alpha  <= n_alpha;
            r_repeat <= n_repeat;
            r_eoi    <= n_eoi;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_alpha        = r_alpha;
    assign o_repeat_res   = r_repeat;
    assign o_end_of_image = r_eoi;

endmodule
